/* rtl/qau_pkg.sv */
// Shared constants for the quaternion arithmetic unit.
// Holds the default component format and the operation codes; no dependencies.
package qau_pkg;

  localparam int QAU_COMP_WIDTH = 16;
  localparam int QAU_FRAC_BITS  = 12;
  localparam int QAU_OP_WIDTH   = 3;

  localparam logic [QAU_OP_WIDTH-1:0] OP_PROD   = 3'd0;
  localparam logic [QAU_OP_WIDTH-1:0] OP_ROTATE = 3'd1;
  localparam logic [QAU_OP_WIDTH-1:0] OP_ADD    = 3'd2;
  localparam logic [QAU_OP_WIDTH-1:0] OP_SUB    = 3'd3;
  localparam logic [QAU_OP_WIDTH-1:0] OP_SCALE  = 3'd4;

endpackage

/* rtl/qau_sat.sv */
// Signed saturation of a wide value to a narrower two's complement range.
// Stand-alone combinational block, no package needed.
module qau_sat #(
  parameter int IN_W  = 35,
  parameter int OUT_W = 16
) (
  input  logic signed [IN_W-1:0]  d,
  output logic signed [OUT_W-1:0] q,
  output logic                    clip
);

  localparam logic signed [IN_W-1:0] HI =
    signed'((IN_W'(1) << (OUT_W - 1)) - IN_W'(1));
  localparam logic signed [IN_W-1:0] LO = ~HI;

  always_comb begin
    clip = 1'b0;
    q    = d[OUT_W-1:0];
    if (d > HI) begin
      clip = 1'b1;
      q    = HI[OUT_W-1:0];
    end else if (d < LO) begin
      clip = 1'b1;
      q    = LO[OUT_W-1:0];
    end
  end

endmodule

/* rtl/quaternion_arith_unit.sv */
// Top level of the quaternion arithmetic unit: five-stage pipeline.
// Depends on qau_pkg (defaults, op codes) and qau_sat (saturation).
//
//   channel   ports                                   handshake
//   input     in_op, in_a_w..in_a_z, in_b_w..in_b_z   start high, busy low
//   result    out_r_w..out_r_z, out_saturated         out_valid, one cycle
//
// One item per clock once out of reset. After its transfer an item passes
// in order through the input register, first multiplier bank, rounding
// and sums, second multiplier bank (rotation only), final sum and saturation.
// Reset is synchronous; busy stays high while rst_n is low and drops on
// the first clock after release. The receiver cannot stall, so the
// pipeline moves every cycle and no item is ever held back.
module quaternion_arith_unit
  import qau_pkg::*;
#(
  parameter int COMP_WIDTH = QAU_COMP_WIDTH,
  parameter int FRAC_BITS  = QAU_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [QAU_OP_WIDTH-1:0]      in_op,
  input  logic signed [COMP_WIDTH-1:0] in_a_w,
  input  logic signed [COMP_WIDTH-1:0] in_a_x,
  input  logic signed [COMP_WIDTH-1:0] in_a_y,
  input  logic signed [COMP_WIDTH-1:0] in_a_z,
  input  logic signed [COMP_WIDTH-1:0] in_b_w,
  input  logic signed [COMP_WIDTH-1:0] in_b_x,
  input  logic signed [COMP_WIDTH-1:0] in_b_y,
  input  logic signed [COMP_WIDTH-1:0] in_b_z,
  output logic                         out_valid,
  output logic signed [COMP_WIDTH-1:0] out_r_w,
  output logic signed [COMP_WIDTH-1:0] out_r_x,
  output logic signed [COMP_WIDTH-1:0] out_r_y,
  output logic signed [COMP_WIDTH-1:0] out_r_z,
  output logic                         out_saturated
);

  localparam int N      = COMP_WIDTH;
  localparam int PROD_W = 2 * COMP_WIDTH;
  localparam int T_W    = PROD_W + 2;
  localparam int ACC_W  = PROD_W + 3;
  localparam logic signed [PROD_W-1:0] HALF = signed'(PROD_W'(1) << (FRAC_BITS - 1));

  logic in_xfer;
  logic busy_r;

  // Stage 0: input register.
  logic                    v0_r;
  logic [QAU_OP_WIDTH-1:0] op0_r;
  logic signed [N-1:0]     a0_r [4];
  logic signed [N-1:0]     b0_r [4];

  // Stage 1: all sixteen a_i * b_j products.
  logic                    v1_r;
  logic [QAU_OP_WIDTH-1:0] op1_r;
  logic signed [N-1:0]     a1_r [4];
  logic signed [N-1:0]     b1_r [4];
  logic signed [PROD_W-1:0] p1_r [4][4];

  // Stage 2: rounded sums and the rotation intermediate t.
  logic                    v2_r;
  logic [QAU_OP_WIDTH-1:0] op2_r;
  logic signed [N-1:0]     a2_r [4];
  logic signed [N-1:0]     bv2_r [3];
  logic signed [ACC_W-1:0] s2_r [4];
  logic signed [N-1:0]     t2_r [3];
  logic                    tclip2_r;
  logic signed [PROD_W-1:0] rnd2 [4][4];
  logic signed [ACC_W-1:0] s2_nxt [4];
  logic signed [T_W-1:0]   traw2 [3];
  logic signed [N-1:0]     tsat2 [3];
  logic [2:0]              tclip2;

  // Stage 3: a_i * t_k products for rotation.
  logic                    v3_r;
  logic [QAU_OP_WIDTH-1:0] op3_r;
  logic signed [N-1:0]     bv3_r [3];
  logic signed [ACC_W-1:0] s3_r [4];
  logic                    tclip3_r;
  logic signed [PROD_W-1:0] m3_r [4][3];

  // Stage 4: final sums, saturation, output register.
  logic signed [PROD_W-1:0] rnd4 [4][3];
  logic signed [ACC_W-1:0] f4 [4];
  logic signed [N-1:0]     q4 [4];
  logic [3:0]              clip4;
  logic                    out_valid_r;
  logic [QAU_OP_WIDTH-1:0] op4_r;
  logic signed [N-1:0]     r_r [4];
  logic                    sat_r;

  assign in_xfer = start && !busy_r;
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      v0_r        <= in_xfer;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    op0_r   <= in_op;
    a0_r[0] <= in_a_w;
    a0_r[1] <= in_a_x;
    a0_r[2] <= in_a_y;
    a0_r[3] <= in_a_z;
    b0_r[0] <= in_b_w;
    b0_r[1] <= in_b_x;
    b0_r[2] <= in_b_y;
    b0_r[3] <= in_b_z;
  end

  always_ff @(posedge clk) begin
    op1_r <= op0_r;
    for (int i = 0; i < 4; i++) begin
      a1_r[i] <= a0_r[i];
      b1_r[i] <= b0_r[i];
      for (int j = 0; j < 4; j++) begin
        p1_r[i][j] <= PROD_W'(a0_r[i]) * PROD_W'(b0_r[j]);
      end
    end
  end

  // Each product is rounded half toward plus infinity before it is summed.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        rnd2[i][j] = (p1_r[i][j] + HALF) >>> FRAC_BITS;
      end
    end
    traw2[0] = (T_W'(rnd2[2][3]) - T_W'(rnd2[3][2])) <<< 1;
    traw2[1] = (T_W'(rnd2[3][1]) - T_W'(rnd2[1][3])) <<< 1;
    traw2[2] = (T_W'(rnd2[1][2]) - T_W'(rnd2[2][1])) <<< 1;
    for (int i = 0; i < 4; i++) begin
      s2_nxt[i] = '0;
    end
    case (op1_r)
      OP_PROD: begin
        s2_nxt[0] = ACC_W'(rnd2[0][0]) - ACC_W'(rnd2[1][1])
                  - ACC_W'(rnd2[2][2]) - ACC_W'(rnd2[3][3]);
        s2_nxt[1] = ACC_W'(rnd2[0][1]) + ACC_W'(rnd2[1][0])
                  + ACC_W'(rnd2[2][3]) - ACC_W'(rnd2[3][2]);
        s2_nxt[2] = ACC_W'(rnd2[0][2]) + ACC_W'(rnd2[2][0])
                  + ACC_W'(rnd2[3][1]) - ACC_W'(rnd2[1][3]);
        s2_nxt[3] = ACC_W'(rnd2[0][3]) + ACC_W'(rnd2[3][0])
                  + ACC_W'(rnd2[1][2]) - ACC_W'(rnd2[2][1]);
      end
      OP_ADD: begin
        for (int i = 0; i < 4; i++) begin
          s2_nxt[i] = ACC_W'(a1_r[i]) + ACC_W'(b1_r[i]);
        end
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          s2_nxt[i] = ACC_W'(a1_r[i]) - ACC_W'(b1_r[i]);
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          s2_nxt[i] = ACC_W'(rnd2[i][0]);
        end
      end
      default: begin
        // Rotation finishes in stage 4; unused codes give zero.
      end
    endcase
  end

  for (genvar k = 0; k < 3; k++) begin : g_tsat
    qau_sat #(.IN_W(T_W), .OUT_W(N)) u_tsat (
      .d    (traw2[k]),
      .q    (tsat2[k]),
      .clip (tclip2[k])
    );
  end

  always_ff @(posedge clk) begin
    op2_r    <= op1_r;
    tclip2_r <= (op1_r == OP_ROTATE) && (|tclip2);
    for (int i = 0; i < 4; i++) begin
      a2_r[i] <= a1_r[i];
      s2_r[i] <= s2_nxt[i];
    end
    for (int k = 0; k < 3; k++) begin
      bv2_r[k] <= b1_r[k+1];
      t2_r[k]  <= tsat2[k];
    end
  end

  always_ff @(posedge clk) begin
    op3_r    <= op2_r;
    tclip3_r <= tclip2_r;
    for (int i = 0; i < 4; i++) begin
      s3_r[i] <= s2_r[i];
      for (int k = 0; k < 3; k++) begin
        m3_r[i][k] <= PROD_W'(a2_r[i]) * PROD_W'(t2_r[k]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      bv3_r[k] <= bv2_r[k];
    end
  end

  // Rotation: v + a_w*t + cross(a_v, t); other ops pass their sums through.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) begin
        rnd4[i][k] = (m3_r[i][k] + HALF) >>> FRAC_BITS;
      end
    end
    if (op3_r == OP_ROTATE) begin
      f4[0] = '0;
      f4[1] = ACC_W'(bv3_r[0]) + ACC_W'(rnd4[0][0])
            + ACC_W'(rnd4[2][2]) - ACC_W'(rnd4[3][1]);
      f4[2] = ACC_W'(bv3_r[1]) + ACC_W'(rnd4[0][1])
            + ACC_W'(rnd4[3][0]) - ACC_W'(rnd4[1][2]);
      f4[3] = ACC_W'(bv3_r[2]) + ACC_W'(rnd4[0][2])
            + ACC_W'(rnd4[1][1]) - ACC_W'(rnd4[2][0]);
    end else begin
      for (int i = 0; i < 4; i++) begin
        f4[i] = s3_r[i];
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_osat
    qau_sat #(.IN_W(ACC_W), .OUT_W(N)) u_osat (
      .d    (f4[i]),
      .q    (q4[i]),
      .clip (clip4[i])
    );
  end

  always_ff @(posedge clk) begin
    op4_r <= op3_r;
    sat_r <= tclip3_r || (|clip4);
    for (int i = 0; i < 4; i++) begin
      r_r[i] <= q4[i];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_r_w       = r_r[0];
  assign out_r_x       = r_r[1];
  assign out_r_y       = r_r[2];
  assign out_r_z       = r_r[3];
  assign out_saturated = sat_r;

  // A result leaves after each transfer, none otherwise.
  a_latency: assert property (@(posedge clk)
    rst_n && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
      && $past(rst_n, 4) && $past(rst_n, 5)
    |-> out_valid == $past(start && !busy, 5))
    else $error("result strobe does not match the transfer five cycles earlier");

  // Rotation never produces a scalar part.
  a_rot_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (op4_r == OP_ROTATE) |-> out_r_w == '0)
    else $error("rotation result has a nonzero scalar part");

  // Unused op codes give an all-zero result without the saturation flag.
  a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (op4_r != OP_PROD) && (op4_r != OP_ROTATE) && (op4_r != OP_ADD)
      && (op4_r != OP_SUB) && (op4_r != OP_SCALE)
    |-> (out_r_w == '0) && (out_r_x == '0) && (out_r_y == '0) && (out_r_z == '0)
      && !out_saturated)
    else $error("unused op code produced a nonzero result");

  // Once out of reset the unit is never busy and can take a transfer on every cycle.
  a_never_busy: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> !busy)
    else $error("busy raised outside of reset");

endmodule
